### sv/mie_pkg.sv
// Package: constants, microcode types and the control store of the modular inverse block
package mie_pkg;

  localparam int unsigned WIDTH_DEF = 30;
  localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TEST,
    S_GROW,
    S_SHRINK,
    S_SWAP,
    S_FINAL
  } step_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IN_FIRE,
    C_B_NZ,
    C_BS_LE_A,
    C_K_NZ,
    C_OUT_FREE
  } cond_t;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_SETUP,
    OP_GROW,
    OP_SHRINK,
    OP_SWAP,
    OP_REDUCE
  } op_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t tgt_t;
    step_t tgt_f;
  } uword_t;

  function automatic uword_t ucode(input step_t step);
    uword_t w;
    unique case (step)
      S_IDLE:   w = '{op: OP_LOAD,   cond: C_IN_FIRE,  tgt_t: S_TEST,   tgt_f: S_IDLE};
      S_TEST:   w = '{op: OP_SETUP,  cond: C_B_NZ,     tgt_t: S_GROW,   tgt_f: S_FINAL};
      S_GROW:   w = '{op: OP_GROW,   cond: C_BS_LE_A,  tgt_t: S_GROW,   tgt_f: S_SHRINK};
      S_SHRINK: w = '{op: OP_SHRINK, cond: C_K_NZ,     tgt_t: S_SHRINK, tgt_f: S_SWAP};
      S_SWAP:   w = '{op: OP_SWAP,   cond: C_ALWAYS,   tgt_t: S_TEST,   tgt_f: S_TEST};
      S_FINAL:  w = '{op: OP_REDUCE, cond: C_OUT_FREE, tgt_t: S_IDLE,   tgt_f: S_FINAL};
      default:  w = '{op: OP_LOAD,   cond: C_ALWAYS,   tgt_t: S_IDLE,   tgt_f: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

### sv/modular_inverse_euclid_top.sv
// Top level: microcoded extended Euclid modular inverse with configurable modulus
// Each Euclid step doubles the divisor in S_GROW while it is at most a, halves it back in
//   S_SHRINK with a conditional subtract, then swaps in S_SWAP; S_FINAL reduces the result.
// Throughput: one item at a time; in_stall is high from transfer in until the result
//   is written to the output register, which then waits for its own transfer.
// Reset: synchronous active low; returns the sequencer to idle, drops out_valid and
//   sets the modulus to 1000000007 (masked to WIDTH bits).
module modular_inverse_euclid_top
  import mie_pkg::*;
#(
  parameter int unsigned WIDTH = WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [WIDTH-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [WIDTH-1:0] in_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WIDTH-1:0] out_inverse
);

  localparam int unsigned KW = $clog2(WIDTH + 1);
  localparam int unsigned SW = WIDTH + 4;

  step_t                 pc_r, pc_nxt;
  uword_t                uw;
  logic                  exec;
  logic                  out_valid_r;
  logic [WIDTH-1:0]      out_data_r;
  logic [WIDTH-1:0]      mod_r;

  logic [WIDTH-1:0]      a_r;
  logic [WIDTH-1:0]      b_r;
  logic [WIDTH:0]        bs_r;
  logic [KW-1:0]         k_r;
  logic signed [SW-1:0]  u_r;
  logic signed [SW-1:0]  v_r;
  logic signed [SW-1:0]  vs_r;

  logic [WIDTH:0]        bs_half;
  logic signed [SW-1:0]  vs_half;
  logic                  take;
  logic [WIDTH:0]        a_diff;
  logic signed [SW-1:0]  m_s;
  logic signed [SW-1:0]  u_red;

  assign uw = ucode(pc_r);

  always_comb begin
    unique case (uw.cond)
      C_ALWAYS:   exec = 1'b1;
      C_IN_FIRE:  exec = in_valid && !in_stall;
      C_B_NZ:     exec = (b_r != '0);
      C_BS_LE_A:  exec = (bs_r <= {1'b0, a_r});
      C_K_NZ:     exec = (k_r != '0);
      C_OUT_FREE: exec = !out_valid_r || !out_stall;
      default:    exec = 1'b0;
    endcase
    pc_nxt = exec ? uw.tgt_t : uw.tgt_f;
  end

  always_comb begin
    bs_half = bs_r >> 1;
    vs_half = vs_r >>> 1;
    take    = (bs_half <= {1'b0, a_r});
    a_diff  = {1'b0, a_r} - bs_half;
    m_s     = $signed({{(SW - WIDTH){1'b0}}, mod_r});
    if (mod_r == '0) begin
      u_red = '0;
    end else if (u_r < 0) begin
      u_red = u_r + m_s;
    end else if (u_r >= m_s) begin
      u_red = u_r - m_s;
    end else begin
      u_red = u_r;
    end
  end

  assign in_stall    = (pc_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_inverse = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      mod_r       <= MODULUS_RESET[WIDTH-1:0];
    end else begin
      pc_r <= pc_nxt;
      if (exec && uw.op == OP_REDUCE) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        mod_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      unique case (uw.op)
        OP_LOAD: begin
          a_r <= in_value;
          b_r <= mod_r;
          u_r <= SW'(1);
          v_r <= '0;
        end
        OP_SETUP: begin
          bs_r <= {1'b0, b_r};
          vs_r <= v_r;
          k_r  <= '0;
        end
        OP_GROW: begin
          bs_r <= bs_r << 1;
          vs_r <= vs_r <<< 1;
          k_r  <= k_r + KW'(1);
        end
        OP_SHRINK: begin
          bs_r <= bs_half;
          vs_r <= vs_half;
          k_r  <= k_r - KW'(1);
          if (take) begin
            a_r <= a_diff[WIDTH-1:0];
            u_r <= u_r - vs_half;
          end
        end
        OP_SWAP: begin
          a_r <= b_r;
          b_r <= a_r;
          u_r <= v_r;
          v_r <= u_r;
        end
        OP_REDUCE: begin
          out_data_r <= u_red[WIDTH-1:0];
        end
        default: begin
          out_data_r <= out_data_r;
        end
      endcase
    end
  end

endmodule

### sv/mie_checker.sv
// Checker: port-level assertions for the modular inverse block, with its bind
module mie_checker
  import mie_pkg::*;
#(
  parameter int unsigned WIDTH = WIDTH_DEF
) (
  input logic             clk,
  input logic             rst_n,
  input logic             cfg_wr_en,
  input logic [WIDTH-1:0] cfg_wr_data,
  input logic             in_valid,
  input logic             in_stall,
  input logic [WIDTH-1:0] in_value,
  input logic             out_valid,
  input logic             out_stall,
  input logic [WIDTH-1:0] out_inverse
);

  logic [WIDTH-1:0] mod_sh_r;
  logic             mod_known_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_known_r <= 1'b0;
    end else if (cfg_wr_en) begin
      mod_known_r <= 1'b1;
      mod_sh_r    <= cfg_wr_data;
    end
  end

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_inverse))
    else $error("stalled result changed or dropped");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not held off after transfer");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mod_known_r && mod_sh_r != '0 |-> out_inverse < mod_sh_r)
    else $error("result not reduced below modulus");

endmodule

bind modular_inverse_euclid_top mie_checker #(.WIDTH(WIDTH)) u_mie_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .cfg_wr_en   (cfg_wr_en),
  .cfg_wr_data (cfg_wr_data),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_value    (in_value),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_inverse (out_inverse)
);

### tb/tb.sv
// Testbench for the extended Euclid modular inverse block: directed and random values
`timescale 1ns / 1ps

module tb;
  import mie_pkg::*;

  localparam int W = WIDTH_DEF;
  localparam logic [W-1:0] ALL_ONES = {W{1'b1}};
  localparam int CYCLE_LIMIT = 1000000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_wr_en = 1'b0;
  logic [W-1:0] cfg_wr_data = '0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  logic [W-1:0] in_value = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  logic [W-1:0] out_inverse;

  logic [W-1:0] modulus_now;
  logic [W-1:0] expected_inverse[$];
  int           send_idle_pct = 24;
  int           recv_idle_pct = 75;
  int           values_sent = 0;
  int           inverses_checked = 0;
  int           modulus_writes = 0;
  int           mismatches = 0;

  modular_inverse_euclid_top #(.WIDTH(W)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_inverse(out_inverse)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [W-1:0] euclid_inverse(input logic [W-1:0] value,
                                                  input logic [W-1:0] m);
    longint a, b, u, v, q, tmp, mm;
    if (m == '0) return '0;
    a = value;
    b = m;
    mm = m;
    u = 1;
    v = 0;
    while (b != 0) begin
      q = a / b;
      a = a - q * b;
      tmp = a; a = b; b = tmp;
      u = u - q * v;
      tmp = u; u = v; v = tmp;
    end
    u = u % mm;
    if (u < 0) u = u + mm;
    return u[W-1:0];
  endfunction

  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_inverse.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected inverse transfer, expected none, actual %0d",
                 $time, out_inverse);
      end else begin
        if (out_inverse !== expected_inverse[0]) begin
          mismatches++;
          $display("%0t: inverse mismatch, expected %0d, actual %0d",
                   $time, expected_inverse[0], out_inverse);
        end
        void'(expected_inverse.pop_front());
        inverses_checked++;
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb: timeout after %0d cycles, %0d inverses outstanding",
             CYCLE_LIMIT, expected_inverse.size());
    $display("tb: done, errors");
    $finish;
  end

  task automatic send_value(input logic [W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_value = v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_inverse.push_back(euclid_inverse(v, modulus_now));
    values_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain_results();
    while (expected_inverse.size() != 0) @(negedge clk);
  endtask

  task automatic write_modulus(input logic [W-1:0] m);
    drain_results();
    repeat (4) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = m;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    modulus_now = m;
    modulus_writes++;
  endtask

  function automatic logic [W-1:0] pick_modulus();
    logic [W-1:0] m;
    case ($urandom_range(4))
      0: m = W'($urandom);
      1: m = W'($urandom_range(2, 1000));
      2: begin
        case ($urandom_range(2))
          0: m = W'(1000000007);
          1: m = W'(998244353);
          default: m = W'(65537);
        endcase
      end
      3: m = ($urandom_range(1) != 0) ? ALL_ONES : W'(2);
      default: m = W'($urandom_range(1, 60)) * W'($urandom_range(2, 1000000));
    endcase
    return m;
  endfunction

  function automatic logic [W-1:0] pick_value();
    logic [W-1:0] v;
    case ($urandom_range(3))
      0: v = W'($urandom);
      1: v = (modulus_now != '0) ? W'($urandom % modulus_now) : W'($urandom);
      2: v = W'($urandom_range(0, 255));
      default: v = modulus_now + W'($urandom_range(0, 3));
    endcase
    return v;
  endfunction

  task automatic test_reset_modulus();
    send_value('0);
    send_value(W'(1));
    send_value(W'(2));
    send_value(W'(1000000006));
    send_value(W'(1000000007));
    send_value(ALL_ONES);
    send_value({(W/2){2'b10}});
  endtask

  task automatic test_degenerate_moduli();
    write_modulus('0);
    send_value('0);
    send_value(W'(5));
    write_modulus(W'(1));
    send_value('0);
    send_value(W'(7));
    write_modulus(W'(2));
    send_value(W'(3));
  endtask

  task automatic test_common_factor();
    write_modulus(W'(360));
    send_value(W'(12));
    send_value(W'(7));
    send_value(W'(1080));
  endtask

  task automatic test_widest_modulus();
    write_modulus(ALL_ONES);
    send_value(ALL_ONES);
    send_value({(W/2){2'b01}});
    send_value({(W/2){2'b10}});
    send_value(W'(2));
  endtask

  task automatic test_random_values();
    int phase, chunk, n;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 24; recv_idle_pct = 75; end
        1: begin send_idle_pct = 75; recv_idle_pct = 24; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (chunk = 0; chunk < 4; chunk++) begin
        write_modulus(pick_modulus());
        for (n = 0; n < 42; n++) begin
          send_value(pick_value());
          if (n == 20 && chunk == 1) drain_results();
        end
      end
    end
  endtask

  initial begin
    modulus_now = MODULUS_RESET[W-1:0];
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_reset_modulus();
    test_degenerate_moduli();
    test_common_factor();
    test_widest_modulus();
    test_random_values();
    drain_results();
    repeat (64) @(posedge clk);
    $display("tb: %0d values sent, %0d inverses checked, %0d modulus writes",
             values_sent, inverses_checked, modulus_writes);
    $display("tb: moduli 0, 1, 2, composite, prime and all ones; three idle mixes");
    if (mismatches == 0 && expected_inverse.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
sv/mie_pkg.sv
sv/modular_inverse_euclid_top.sv
sv/mie_checker.sv
tb/tb.sv
